// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define BFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define BFT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/bft_pkg.sv -----
// Package of the build-file tokenizer: character codes, lexer modes,
// result codes, the result record and the per-byte result bundle.
// No dependencies.
`default_nettype none

package bft_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_RES         = 4;
  localparam int REC_IDX_W       = $clog2(MAX_RES);
  localparam int REC_CNT_W       = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SLASH = 4'd1;
  localparam logic [3:0] M_LCOMM = 4'd2;
  localparam logic [3:0] M_BLOCK = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_STR   = 4'd5;
  localparam logic [3:0] M_ESC   = 4'd6;
  localparam logic [3:0] M_INT   = 4'd7;
  localparam logic [3:0] M_IDENT = 4'd8;
  localparam logic [3:0] M_ERR   = 4'd9;

  localparam logic [1:0] EV_VALUE = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [3:0] K_NONE  = 4'd0;
  localparam logic [3:0] K_STR   = 4'd10;
  localparam logic [3:0] K_INT   = 4'd11;
  localparam logic [3:0] K_IDENT = 4'd12;
  localparam logic [3:0] K_END   = 4'd13;

  localparam logic [1:0] ERR_CHAR    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  kind;
    logic [7:0]  value_byte;
    logic [15:0] line_number;
    logic [1:0]  error_code;
  } rec_t;

  typedef struct packed {
    rec_t [MAX_RES-1:0]   rec;
    logic [REC_CNT_W-1:0] cnt;
  } bundle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  // Returns the hit flag in bit 4 and the punctuation kind in bits 3:0.
  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      CH_LBRACE: r = {1'b1, 4'd0};
      CH_RBRACE: r = {1'b1, 4'd1};
      CH_LBRACK: r = {1'b1, 4'd2};
      CH_RBRACK: r = {1'b1, 4'd3};
      CH_COLON:  r = {1'b1, 4'd4};
      CH_COMMA:  r = {1'b1, 4'd5};
      CH_PLUS:   r = {1'b1, 4'd6};
      CH_EQUAL:  r = {1'b1, 4'd7};
      CH_LPAREN: r = {1'b1, 4'd8};
      CH_RPAREN: r = {1'b1, 4'd9};
      default:   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic bundle_t add_rec(bundle_t b, logic [1:0] ev, logic [3:0] kd,
                                      logic [7:0] val, logic [15:0] ln,
                                      logic [1:0] code);
    rec_t r;
    r.event_res   = ev;
    r.kind        = kd;
    r.value_byte  = val;
    r.line_number = ln;
    r.error_code  = code;
    if (b.cnt < REC_CNT_W'(MAX_RES)) begin
      b.rec[b.cnt[REC_IDX_W-1:0]] = r;
      b.cnt = b.cnt + REC_CNT_W'(1);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bft_if.sv -----
// Valid/ready channel interfaces of the tokenizer: source bytes in,
// result items out. No dependencies.
`default_nettype none

interface bft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface bft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [3:0]  kind;
  logic [7:0]  value_byte;
  logic [15:0] line_number;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output event_res, output kind, output value_byte,
                  output line_number, output error_code, output last_of_run,
                  input ready);
  modport sink (input valid, input event_res, input kind, input value_byte,
                input line_number, input error_code, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bft_front.sv -----
// Lexer front end: accepts one source byte per cycle while the queue is not full, runs the mode machine
// and emits a bundle of up to four result records. Uses bft_pkg, bft_if.
`default_nettype none

module bft_front #(
  parameter int LINE_BITS = bft_pkg::LINE_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  bft_in_if.sink           in_ch,
  input  wire              full,
  output logic             push,
  output bft_pkg::bundle_t bnd
);
  import bft_pkg::*;
  `include "assert_macros.svh"

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  logic [3:0]           mode_r, mode_nxt;
  logic [LINE_BITS-1:0] cur_r, cur_nxt;
  logic [LINE_BITS-1:0] start_r, start_nxt;
  logic                 accept;
  logic                 eos_accept;
  logic                 at_reset_state;

  function automatic logic [15:0] disp(logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+15:0] w;
    w = {16'd0, v};
    return w[15:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] inc_line(logic [LINE_BITS-1:0] v);
    return (v == {LINE_BITS{1'b1}}) ? v : v + LINE_BITS'(1);
  endfunction

  assign in_ch.ready    = !full;
  assign accept         = in_ch.valid && in_ch.ready;
  assign push           = accept && (bnd.cnt != '0);
  assign eos_accept     = accept && in_ch.end_of_source;
  assign at_reset_state = (mode_r == M_IDLE) && (cur_r == LINE_ONE) && (start_r == LINE_ONE);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    logic [4:0] pk;
    logic       do_idle;
    c         = in_ch.char_byte;
    d         = c;
    pk        = punct_kind(c);
    do_idle   = 1'b0;
    mode_nxt  = mode_r;
    cur_nxt   = cur_r;
    start_nxt = start_r;
    bnd       = '0;

    unique case (mode_r)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = M_LCOMM;
        end else if (c == CH_STAR) begin
          start_nxt = cur_nxt;
          mode_nxt  = M_BLOCK;
        end else begin
          bnd      = add_rec(bnd, EV_ERROR, K_NONE, 8'd0, disp(cur_nxt), ERR_CHAR);
          mode_nxt = M_ERR;
        end
      end
      M_LCOMM: begin
        if (c == CH_LF) begin
          cur_nxt  = inc_line(cur_nxt);
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) begin
          mode_nxt = M_BSTAR;
        end else if (c == CH_LF) begin
          cur_nxt = inc_line(cur_nxt);
        end
      end
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          mode_nxt = M_IDLE;
        end else if (c != CH_STAR) begin
          if (c == CH_LF) begin
            cur_nxt = inc_line(cur_nxt);
          end
          mode_nxt = M_BLOCK;
        end
      end
      M_STR: begin
        if (c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else if (c == CH_QUOTE) begin
          bnd      = add_rec(bnd, EV_DONE, K_STR, 8'd0, disp(start_nxt), ERR_CHAR);
          mode_nxt = M_IDLE;
        end else begin
          if (c == CH_LF) begin
            cur_nxt = inc_line(cur_nxt);
          end
          bnd = add_rec(bnd, EV_VALUE, K_STR, c, disp(start_nxt), ERR_CHAR);
        end
      end
      M_ESC: begin
        mode_nxt = M_STR;
        if (c == CH_LF) begin
          cur_nxt = inc_line(cur_nxt);
        end else begin
          if (c == CH_LOW_N) begin
            d = CH_LF;
          end else if (c == CH_LOW_T) begin
            d = CH_TAB;
          end else if (c == CH_LOW_R) begin
            d = CH_CR;
          end
          bnd = add_rec(bnd, EV_VALUE, K_STR, d, disp(start_nxt), ERR_CHAR);
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          bnd = add_rec(bnd, EV_VALUE, K_INT, c, disp(start_nxt), ERR_CHAR);
        end else begin
          bnd     = add_rec(bnd, EV_DONE, K_INT, 8'd0, disp(start_nxt), ERR_CHAR);
          do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          bnd = add_rec(bnd, EV_VALUE, K_IDENT, c, disp(start_nxt), ERR_CHAR);
        end else begin
          bnd     = add_rec(bnd, EV_DONE, K_IDENT, 8'd0, disp(start_nxt), ERR_CHAR);
          do_idle = 1'b1;
        end
      end
      M_ERR: begin
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // A byte seen outside any token, including the byte that ended a number or identifier.
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (c == CH_LF) begin
        cur_nxt = inc_line(cur_nxt);
      end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)) begin
        mode_nxt = M_IDLE;
      end else if (c == CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else if (pk[4]) begin
        start_nxt = cur_nxt;
        bnd = add_rec(bnd, EV_VALUE, pk[3:0], c, disp(cur_nxt), ERR_CHAR);
        bnd = add_rec(bnd, EV_DONE, pk[3:0], 8'd0, disp(cur_nxt), ERR_CHAR);
      end else if (c == CH_QUOTE) begin
        start_nxt = cur_nxt;
        mode_nxt  = M_STR;
      end else if (is_digit(c)) begin
        start_nxt = cur_nxt;
        bnd       = add_rec(bnd, EV_VALUE, K_INT, c, disp(cur_nxt), ERR_CHAR);
        mode_nxt  = M_INT;
      end else if (is_alpha(c)) begin
        start_nxt = cur_nxt;
        bnd       = add_rec(bnd, EV_VALUE, K_IDENT, c, disp(cur_nxt), ERR_CHAR);
        mode_nxt  = M_IDENT;
      end else begin
        bnd      = add_rec(bnd, EV_ERROR, K_NONE, 8'd0, disp(cur_nxt), ERR_CHAR);
        mode_nxt = M_ERR;
      end
    end

    // The last byte closes what is pending and returns to the reset state.
    if (in_ch.end_of_source) begin
      unique case (mode_nxt) inside
        M_INT: begin
          bnd = add_rec(bnd, EV_DONE, K_INT, 8'd0, disp(start_nxt), ERR_CHAR);
        end
        M_IDENT: begin
          bnd = add_rec(bnd, EV_DONE, K_IDENT, 8'd0, disp(start_nxt), ERR_CHAR);
        end
        M_SLASH: begin
          bnd = add_rec(bnd, EV_ERROR, K_NONE, 8'd0, disp(cur_nxt), ERR_CHAR);
        end
        M_BLOCK, M_BSTAR: begin
          bnd = add_rec(bnd, EV_ERROR, K_NONE, 8'd0, disp(start_nxt), ERR_COMMENT);
        end
        M_STR, M_ESC: begin
          bnd = add_rec(bnd, EV_ERROR, K_NONE, 8'd0, disp(start_nxt), ERR_STRING);
        end
        default: begin
        end
      endcase
      if ((mode_nxt != M_ERR) && (mode_nxt != M_SLASH) && (mode_nxt != M_BLOCK) &&
          (mode_nxt != M_BSTAR) && (mode_nxt != M_STR) && (mode_nxt != M_ESC)) begin
        bnd = add_rec(bnd, EV_DONE, K_END, 8'd0, disp(cur_nxt), ERR_CHAR);
      end
      mode_nxt  = M_IDLE;
      cur_nxt   = LINE_ONE;
      start_nxt = LINE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      cur_r   <= LINE_ONE;
      start_r <= LINE_ONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
    end
  end

  `BFT_ASSERT(a_push_has_records, push |-> (bnd.cnt != '0), "empty bundle pushed")
  `BFT_ASSERT_NEXT(a_eos_resets, eos_accept, at_reset_state, "state not reset after last byte")

endmodule

`default_nettype wire

// ----- rtl/core/bft_queue.sv -----
// Short bundle queue between the lexer front end and the result serializer.
// Uses bft_pkg.
`default_nettype none

module bft_queue #(
  parameter int DEPTH = bft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  bft_pkg::bundle_t wr_bnd,
  input  wire              pop,
  output bft_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import bft_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bundle_t            mem_r [DEPTH];
  bundle_t            head_r;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The head register follows the entry at the next read pointer, taking the
  // incoming bundle when it lands in that same entry.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_bnd;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_bnd;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  `BFT_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
  `BFT_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ----- rtl/core/bft_back.sv -----
// Result serializer: walks the records of the queue head onto the result channel,
// one per cycle while the receiver is ready, and marks the last one. Uses bft_pkg, bft_if.
`default_nettype none

module bft_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              empty,
  input  bft_pkg::bundle_t head,
  output logic             pop,
  bft_out_if.source        out_ch
);
  import bft_pkg::*;
  `include "assert_macros.svh"

  logic [REC_IDX_W-1:0] idx_r, idx_nxt;
  rec_t                 rec;
  logic                 last;
  logic                 take;

  assign rec  = head.rec[idx_r];
  assign last = ({1'b0, idx_r} + REC_CNT_W'(1)) == head.cnt;
  assign take = out_ch.valid && out_ch.ready;
  assign pop  = take && last;

  assign out_ch.valid       = !empty;
  assign out_ch.event_res   = rec.event_res;
  assign out_ch.kind        = rec.kind;
  assign out_ch.value_byte  = rec.value_byte;
  assign out_ch.line_number = rec.line_number;
  assign out_ch.error_code  = rec.error_code;
  assign out_ch.last_of_run = last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? '0 : idx_r + REC_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `BFT_ASSERT(a_idx_in_bundle, out_ch.valid |-> ({1'b0, idx_r} < head.cnt), "bad record index")

endmodule

`default_nettype wire

// ----- rtl/core/build_file_tokenizer_top.sv -----
// Top level of the build-file tokenizer: front end, bundle queue, serializer.
// Uses bft_pkg, bft_if, bft_front, bft_queue, bft_back.
//
// Usage:
// in_ch carries one source byte per item, with end_of_source set on the last
// byte of a source. out_ch carries result items: value bytes, token-complete
// events with kind and start line, and errors; last_of_run marks the final
// result caused by one input byte. Bytes that cause no result give no item.
// The front end takes one byte per cycle while the queue has room, turning it
// into a bundle of up to four results in the same cycle; the queue registers
// the bundle for the serializer, which sends one result per cycle while the
// receiver is ready. So throughput is one byte per cycle while bytes cause at
// most one result each, and a byte with several results holds the output
// until all are sent. The queue holds QUEUE_DEPTH bundles; when the receiver
// stalls, the queue fills and in_ch.ready drops until space returns.
// Synchronous reset puts the lexer in idle with line 1 and empties the queue.
// After the last byte of a source, the state returns to the same values.
`default_nettype none

module build_file_tokenizer_top #(
  parameter int LINE_BITS   = bft_pkg::LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = bft_pkg::QUEUE_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  bft_in_if.sink    in_ch,
  bft_out_if.source out_ch
);
  import bft_pkg::*;

  bundle_t bnd;
  bundle_t head;
  logic    push;
  logic    pop;
  logic    empty;
  logic    full;

  bft_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .bnd   (bnd)
  );

  bft_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_bnd (bnd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  bft_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for build_file_tokenizer_top: directed and random
// source text with a predictor of the token, error and line results.
// Uses bft_pkg, the bft_in_if/bft_out_if interfaces and the tokenizer RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bft_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PRESSURE_HOLD = 300;
  localparam int PHASE_ITEMS = 55;
  localparam int DIR_ROWS = 24;
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [7:0] PUNCT_SET [10] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                            CH_COLON, CH_COMMA, CH_PLUS, CH_EQUAL,
                                            CH_LPAREN, CH_RPAREN};
  localparam int SEND_IDLE [4] = '{0, 75, 0, 35};
  localparam int RECV_STALL [4] = '{0, 0, 75, 35};

  typedef struct packed {
    rec_t rec;
    logic last;
  } tok_event_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eos;
    logic       fixed;
    tok_event_t want;
  } drive_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bft_in_if in_ch ();
  bft_out_if out_ch ();

  build_file_tokenizer_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [3:0]  scan_mode;
  logic [15:0] scan_line;
  logic [15:0] token_line;
  tok_event_t  step_out[$];
  tok_event_t  pending_events[$];
  logic [7:0]  src_text[$];
  drive_row_t  dir_rows [DIR_ROWS];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;
  int mismatches;
  int busy_items;
  int bytes_sent;
  int sources_sent;
  int results_seen;
  int tokens_seen;
  int errors_seen;

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic int punct_index(logic [7:0] c);
    for (int k = 0; k < 10; k++) begin
      if (c == PUNCT_SET[k]) return k;
    end
    return -1;
  endfunction

  function automatic void put_text(logic [7:0] c);
    src_text.insert(src_text.size(), c);
  endfunction

  function automatic void put_expect(tok_event_t t);
    pending_events.insert(pending_events.size(), t);
  endfunction

  function automatic tok_event_t ev_rec(logic [1:0] ev, logic [3:0] kd, logic [7:0] v,
                                        logic [15:0] ln, logic [1:0] code);
    tok_event_t t;
    t.rec.event_res = ev;
    t.rec.kind = kd;
    t.rec.value_byte = v;
    t.rec.line_number = ln;
    t.rec.error_code = code;
    t.last = 1'b1;
    return t;
  endfunction

  function automatic drive_row_t free_row(logic [7:0] c, logic eos);
    return '{c: c, eos: eos, fixed: 1'b0, want: '0};
  endfunction

  function automatic drive_row_t fixed_row(logic [7:0] c, logic eos, logic [1:0] ev,
                                           logic [3:0] kd, logic [7:0] v, logic [15:0] ln,
                                           logic [1:0] code);
    return '{c: c, eos: eos, fixed: 1'b1, want: ev_rec(ev, kd, v, ln, code)};
  endfunction

  function automatic void add_event(logic [1:0] ev, logic [3:0] kd, logic [7:0] v,
                                    logic [15:0] ln, logic [1:0] code);
    tok_event_t t;
    t = ev_rec(ev, kd, v, ln, code);
    t.last = 1'b0;
    if (step_out.size() < MAX_RES) step_out.insert(step_out.size(), t);
  endfunction

  function automatic void bump_line();
    if (scan_line != 16'hFFFF) scan_line++;
  endfunction

  function automatic void raise_error(logic [1:0] code, logic [15:0] ln);
    add_event(EV_ERROR, K_NONE, 8'h00, ln, code);
    scan_mode = M_ERR;
  endfunction

  function automatic void scan_fresh(logic [7:0] c);
    int k;
    k = punct_index(c);
    scan_mode = M_IDLE;
    if (c == CH_LF) begin
      bump_line();
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
    end else if (c == CH_SLASH) begin
      scan_mode = M_SLASH;
    end else if (k >= 0) begin
      token_line = scan_line;
      add_event(EV_VALUE, 4'(k), c, scan_line, CODE_NONE);
      add_event(EV_DONE, 4'(k), 8'h00, scan_line, CODE_NONE);
    end else if (c == CH_QUOTE) begin
      token_line = scan_line;
      scan_mode = M_STR;
    end else if (digit_char(c)) begin
      token_line = scan_line;
      add_event(EV_VALUE, K_INT, c, token_line, CODE_NONE);
      scan_mode = M_INT;
    end else if (word_char(c)) begin
      token_line = scan_line;
      add_event(EV_VALUE, K_IDENT, c, token_line, CODE_NONE);
      scan_mode = M_IDENT;
    end else begin
      raise_error(ERR_CHAR, scan_line);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic eos);
    logic [7:0] d;
    step_out.delete();
    case (scan_mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          scan_mode = M_LCOMM;
        end else if (c == CH_STAR) begin
          token_line = scan_line;
          scan_mode = M_BLOCK;
        end else begin
          raise_error(ERR_CHAR, scan_line);
        end
      end
      M_LCOMM: begin
        if (c == CH_LF) begin
          bump_line();
          scan_mode = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) scan_mode = M_BSTAR;
        else if (c == CH_LF) bump_line();
      end
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          scan_mode = M_IDLE;
        end else if (c != CH_STAR) begin
          if (c == CH_LF) bump_line();
          scan_mode = M_BLOCK;
        end
      end
      M_STR: begin
        if (c == CH_BSLASH) begin
          scan_mode = M_ESC;
        end else if (c == CH_QUOTE) begin
          add_event(EV_DONE, K_STR, 8'h00, token_line, CODE_NONE);
          scan_mode = M_IDLE;
        end else begin
          if (c == CH_LF) bump_line();
          add_event(EV_VALUE, K_STR, c, token_line, CODE_NONE);
        end
      end
      M_ESC: begin
        scan_mode = M_STR;
        if (c == CH_LF) begin
          bump_line();
        end else begin
          d = c;
          if (c == CH_LOW_N) d = CH_LF;
          else if (c == CH_LOW_T) d = CH_TAB;
          else if (c == CH_LOW_R) d = CH_CR;
          add_event(EV_VALUE, K_STR, d, token_line, CODE_NONE);
        end
      end
      M_INT: begin
        if (digit_char(c)) begin
          add_event(EV_VALUE, K_INT, c, token_line, CODE_NONE);
        end else begin
          add_event(EV_DONE, K_INT, 8'h00, token_line, CODE_NONE);
          scan_fresh(c);
        end
      end
      M_IDENT: begin
        if (digit_char(c) || word_char(c)) begin
          add_event(EV_VALUE, K_IDENT, c, token_line, CODE_NONE);
        end else begin
          add_event(EV_DONE, K_IDENT, 8'h00, token_line, CODE_NONE);
          scan_fresh(c);
        end
      end
      M_ERR: begin
      end
      default: scan_fresh(c);
    endcase
    if (eos) begin
      case (scan_mode) inside
        M_INT: add_event(EV_DONE, K_INT, 8'h00, token_line, CODE_NONE);
        M_IDENT: add_event(EV_DONE, K_IDENT, 8'h00, token_line, CODE_NONE);
        M_SLASH: raise_error(ERR_CHAR, scan_line);
        M_BLOCK, M_BSTAR: raise_error(ERR_COMMENT, token_line);
        M_STR, M_ESC: raise_error(ERR_STRING, token_line);
        default: begin
        end
      endcase
      if (scan_mode != M_ERR) add_event(EV_DONE, K_END, 8'h00, scan_line, CODE_NONE);
      scan_mode = M_IDLE;
      scan_line = 16'd1;
      token_line = 16'd1;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SLASH ||
           c == CH_QUOTE || digit_char(c) || word_char(c) || punct_index(c) >= 0)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic void gen_gap();
    case ($urandom_range(5))
      0: put_text(CH_SPACE);
      1: put_text(CH_TAB);
      2: put_text(CH_CR);
      3: put_text(CH_LF);
      default: begin
      end
    endcase
  endfunction

  function automatic void gen_word();
    logic [7:0] c;
    c = pick_word_char();
    while (digit_char(c)) c = pick_word_char();
    put_text(c);
    repeat ($urandom_range(4)) put_text(pick_word_char());
  endfunction

  function automatic void gen_number();
    repeat ($urandom_range(1, 4)) put_text(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void gen_string(bit closed);
    logic [7:0] c;
    put_text(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      case ($urandom_range(9)) inside
        [0:2]: begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
          put_text(c);
        end
        3: put_text(8'($urandom_range(128, 255)));
        4: begin
          put_text(CH_BSLASH);
          case ($urandom_range(2))
            0: put_text(CH_LOW_N);
            1: put_text(CH_LOW_T);
            default: put_text(CH_LOW_R);
          endcase
        end
        5: begin
          put_text(CH_BSLASH);
          put_text(8'($urandom_range(255)));
        end
        6: begin
          put_text(CH_BSLASH);
          put_text(CH_LF);
        end
        7: put_text(CH_LF);
        8: put_text(8'($urandom_range(31)));
        default: put_text(pick_word_char());
      endcase
    end
    if (closed) put_text(CH_QUOTE);
  endfunction

  function automatic void gen_block(bit closed);
    logic [7:0] c;
    put_text(CH_SLASH);
    put_text(CH_STAR);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(3))
        0: put_text(CH_STAR);
        1: put_text(CH_LF);
        default: begin
          c = 8'($urandom_range(255));
          if (c == CH_SLASH) c = CH_SPACE;
          put_text(c);
        end
      endcase
    end
    if (closed) begin
      repeat ($urandom_range(1, 2)) put_text(CH_STAR);
      put_text(CH_SLASH);
    end
  endfunction

  function automatic void gen_line_comment();
    logic [7:0] c;
    put_text(CH_SLASH);
    put_text(CH_SLASH);
    repeat ($urandom_range(5)) begin
      c = 8'($urandom_range(255));
      if (c == CH_LF) c = CH_SPACE;
      put_text(c);
    end
    put_text(CH_LF);
  endfunction

  function automatic void gen_token();
    case ($urandom_range(6)) inside
      [0:1]: put_text(PUNCT_SET[$urandom_range(9)]);
      2: gen_word();
      3: gen_number();
      4: gen_string(1'b1);
      5: gen_line_comment();
      default: gen_block(1'b1);
    endcase
  endfunction

  // Mostly well-formed text, some with a broken tail, some plain noise.
  function automatic void build_source();
    int shape;
    shape = $urandom_range(99);
    src_text.delete();
    if (shape < 12) begin
      repeat ($urandom_range(1, 8)) put_text(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        gen_gap();
        gen_token();
      end
      gen_gap();
      if (shape >= 80) begin
        case ($urandom_range(3))
          0: gen_string(1'b0);
          1: gen_block(1'b0);
          2: begin
            put_text(CH_SLASH);
            if ($urandom_range(1)) put_text(pick_word_char());
          end
          default: begin
            put_text(bad_byte());
            repeat ($urandom_range(3)) gen_token();
          end
        endcase
      end
    end
    if (src_text.size() == 0) put_text(CH_SPACE);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eos, input logic fixed,
                           input tok_event_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.end_of_source <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_byte(c, eos);
    bytes_sent++;
    if (step_out.size() > 0) busy_items++;
    if (fixed) put_expect(want);
    else foreach (step_out[i]) put_expect(step_out[i]);
    @(negedge clk);
  endtask

  task automatic send_source();
    foreach (src_text[i]) send_byte(src_text[i], i == src_text.size() - 1, 1'b0, '0);
    sources_sent++;
  endtask

  function automatic string show(tok_event_t t);
    return $sformatf("event=%0d kind=%0d value=%02h line=%0d code=%0d last=%0b",
                     t.rec.event_res, t.rec.kind, t.rec.value_byte, t.rec.line_number,
                     t.rec.error_code, t.last);
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = PRESSURE_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tok_event_t got;
    tok_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rec.event_res = out_ch.event_res;
      got.rec.kind = out_ch.kind;
      got.rec.value_byte = out_ch.value_byte;
      got.rec.line_number = out_ch.line_number;
      got.rec.error_code = out_ch.error_code;
      got.last = out_ch.last_of_run;
      results_seen++;
      if (got.rec.event_res == EV_ERROR) errors_seen++;
      else if (got.rec.event_res == EV_DONE) tokens_seen++;
      if (pending_events.size() == 0) begin
        if (mismatches < 10) $display("Unexpected result: %s", show(got));
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("Mismatch on result %0d:", results_seen);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding.",
               cycle_count, pending_events.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_start;
    in_ch.valid = 1'b0;
    in_ch.char_byte = 8'h00;
    in_ch.end_of_source = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    scan_mode = M_IDLE;
    scan_line = 16'd1;
    token_line = 16'd1;
    dir_rows = '{
      fixed_row(CH_SPACE,  1'b1, EV_DONE,  K_END,  8'h00, 16'd1, CODE_NONE),
      free_row (CH_SLASH,  1'b0),
      fixed_row(CH_PLUS,   1'b0, EV_ERROR, K_NONE, 8'h00, 16'd1, ERR_CHAR),
      free_row (8'hFF,     1'b1),
      fixed_row("0",       1'b0, EV_VALUE, K_INT,  "0",   16'd1, CODE_NONE),
      free_row ("9",       1'b0),
      free_row (CH_LBRACE, 1'b0),
      free_row ("Z",       1'b0),
      free_row (CH_QUOTE,  1'b0),
      free_row (CH_BSLASH, 1'b0),
      free_row (CH_LOW_N,  1'b0),
      free_row (CH_BSLASH, 1'b0),
      free_row (CH_LF,     1'b0),
      free_row (CH_LF,     1'b0),
      free_row (CH_QUOTE,  1'b0),
      free_row (CH_SLASH,  1'b0),
      free_row (CH_STAR,   1'b0),
      free_row (CH_STAR,   1'b0),
      free_row (CH_SLASH,  1'b1),
      fixed_row(CH_SLASH,  1'b1, EV_ERROR, K_NONE, 8'h00, 16'd1, ERR_CHAR),
      free_row (CH_QUOTE,  1'b0),
      free_row (8'h00,     1'b1),
      free_row (CH_SLASH,  1'b0),
      fixed_row(CH_STAR,   1'b1, EV_ERROR, K_NONE, 8'h00, 16'd1, ERR_COMMENT)
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].c, dir_rows[i].eos, dir_rows[i].fixed, dir_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      if (p == 0) begin
        hold_req = 1'b1;
        src_text.delete();
        repeat (60) put_text(PUNCT_SET[$urandom_range(9)]);
        send_source();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        build_source();
        send_source();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d source bytes in %0d sources, %0d of them with results; %0d checked.",
             bytes_sent, sources_sent, busy_items, results_seen);
    $display("Saw %0d tokens and %0d errors over four idle/stall mixes and a %0d-cycle hold.",
             tokens_seen, errors_seen, PRESSURE_HOLD);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bft_pkg.sv
rtl/core/bft_if.sv
rtl/core/bft_front.sv
rtl/core/bft_queue.sv
rtl/core/bft_back.sv
rtl/core/build_file_tokenizer_top.sv
sim/testbench.sv
